/* hw/rtl/interrupt_event_statistics_unit_macros.svh */
// ============================================================================
// interrupt_event_statistics_unit_macros.svh
// Assertion macros used by the interrupt statistics port checker.
// ============================================================================
`ifndef INTERRUPT_EVENT_STATISTICS_UNIT_MACROS_SVH
`define INTERRUPT_EVENT_STATISTICS_UNIT_MACROS_SVH

// same-cycle implication
`define IESU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define IESU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/iesu_pkg.sv */
// ============================================================================
// iesu_pkg
// Shared types and constants of the interrupt statistics unit.
// ============================================================================
package iesu_pkg;

    localparam int NUM_CPUS_DEF    = 64;
    localparam int NUM_VECTORS_DEF = 256;

    localparam int CNT_W  = 64;
    localparam int IDX_W  = 8;
    localparam int CMD_W  = 2;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 264;

    localparam logic [CMD_W-1:0] CMD_EVENT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic clr_en;
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } dp_status_t;

endpackage

/* hw/rtl/iesu_ctrl.sv */
// ============================================================================
// iesu_ctrl
// Sequencer: post-reset clear sweep, item capture, update and write back.
// ============================================================================
module iesu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  m_tready,
    input  iesu_pkg::dp_status_t  status,
    output iesu_pkg::ctrl_cmd_t   cmd
);
    import iesu_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE);
        cmd.clr_en  = (state_reg == ST_CLEAR);
        cmd.capture = (state_reg == ST_IDLE) && s_tvalid;
        cmd.commit  = (state_reg == ST_UPDATE) && (!status.out_busy || m_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (cmd.commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

/* hw/rtl/iesu_dpath.sv */
// ============================================================================
// iesu_dpath
// Counter memories, read-modify-write update and result register.
// ============================================================================
module iesu_dpath #(
    parameter int NUM_CPUS    = iesu_pkg::NUM_CPUS_DEF,
    parameter int NUM_VECTORS = iesu_pkg::NUM_VECTORS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  iesu_pkg::ctrl_cmd_t         cmd,
    output iesu_pkg::dp_status_t        status,
    input  logic [iesu_pkg::CMD_W-1:0]  in_cmd,
    input  logic [iesu_pkg::IDX_W-1:0]  in_cpu,
    input  logic [iesu_pkg::IDX_W-1:0]  in_vector,
    input  logic                        in_handled,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [iesu_pkg::OUT_W-1:0]  m_tdata
);
    import iesu_pkg::*;

    localparam int EV_DEPTH = NUM_CPUS * NUM_VECTORS;
    localparam int AW       = (EV_DEPTH > 1) ? $clog2(EV_DEPTH) : 1;
    localparam int CIW      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int VIW      = $clog2(NUM_VECTORS);
    localparam int MW       = 2 * IDX_W + 1;

    logic [CNT_W-1:0]   ev_mem  [EV_DEPTH];
    logic [2*CNT_W-1:0] vec_mem [NUM_VECTORS];
    logic [CNT_W-1:0]   cpu_mem [NUM_CPUS];

    logic [NUM_VECTORS-1:0] vec_vld_reg;
    logic [NUM_CPUS-1:0]    cpu_vld_reg;
    logic [AW-1:0]          clr_cnt_reg;

    logic [CMD_W-1:0]   cmd_reg;
    logic [IDX_W-1:0]   cpu_reg;
    logic [IDX_W-1:0]   vec_reg;
    logic               hnd_reg;
    logic [AW-1:0]      ev_addr_reg;
    logic [CNT_W-1:0]   ev_rd_reg;
    logic [2*CNT_W-1:0] vec_rd_reg;
    logic [CNT_W-1:0]   cpu_rd_reg;
    logic               vec_vld_rd_reg;
    logic               cpu_vld_rd_reg;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic [MW-1:0]      ev_addr_in;
    logic               in_cpu_ok;
    logic               in_vec_ok;
    logic               cpu_ok;
    logic               vec_ok;
    logic               is_event;
    logic               is_clear;
    logic [CNT_W-1:0]   tot_cur;
    logic [CNT_W-1:0]   strk_cur;
    logic [CNT_W-1:0]   unh_cur;
    logic [CNT_W-1:0]   cnt_new;
    logic [CNT_W-1:0]   tot_new;
    logic [CNT_W-1:0]   unh_new;
    logic [CNT_W-1:0]   strk_new;
    logic               seen_new;
    logic [OUT_W-1:0]   out_data_next;

    assign ev_addr_in = MW'(in_cpu) * MW'(NUM_VECTORS) + MW'(in_vector);
    assign in_cpu_ok  = ({1'b0, in_cpu} < 9'(NUM_CPUS));
    assign in_vec_ok  = ({1'b0, in_vector} < 9'(NUM_VECTORS));
    assign cpu_ok     = ({1'b0, cpu_reg} < 9'(NUM_CPUS));
    assign vec_ok     = ({1'b0, vec_reg} < 9'(NUM_VECTORS));

    assign status.clr_last = (clr_cnt_reg == AW'(EV_DEPTH - 1));
    assign status.out_busy = out_valid_reg;

    always_comb
    begin
        is_event = (cmd_reg == CMD_EVENT) && cpu_ok && vec_ok;
        is_clear = (cmd_reg == CMD_CLEAR) && vec_ok;
        tot_cur  = vec_vld_rd_reg ? vec_rd_reg[CNT_W-1:0] : '0;
        strk_cur = vec_vld_rd_reg ? vec_rd_reg[2*CNT_W-1:CNT_W] : '0;
        unh_cur  = cpu_vld_rd_reg ? cpu_rd_reg : '0;
        cnt_new  = is_event ? ev_rd_reg + 1'b1 : ev_rd_reg;
        tot_new  = is_event ? tot_cur + 1'b1 : tot_cur;
        unh_new  = (is_event && !hnd_reg) ? unh_cur + 1'b1 : unh_cur;
        if (is_event)
            strk_new = hnd_reg ? '0 : strk_cur + 1'b1;
        else if (is_clear)
            strk_new = '0;
        else
            strk_new = strk_cur;
        seen_new = vec_vld_rd_reg || is_event;

        out_data_next = '0;
        out_data_next[CNT_W-1:0]         = (cpu_ok && vec_ok) ? cnt_new : '0;
        out_data_next[2*CNT_W-1:CNT_W]   = vec_ok ? tot_new : '0;
        out_data_next[3*CNT_W-1:2*CNT_W] = cpu_ok ? unh_new : '0;
        out_data_next[4*CNT_W-1:3*CNT_W] = vec_ok ? strk_new : '0;
        out_data_next[4*CNT_W]           = vec_ok && seen_new;
        out_data_next[4*CNT_W+1]         = cpu_ok;
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
            ev_mem[clr_cnt_reg] <= '0;
        else if (cmd.commit && is_event)
            ev_mem[ev_addr_reg] <= cnt_new;
        if (cmd.capture)
            ev_rd_reg <= ev_mem[ev_addr_in[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && (is_event || is_clear))
            vec_mem[vec_reg[VIW-1:0]] <= {strk_new, tot_new};
        if (cmd.capture)
            vec_rd_reg <= vec_mem[in_vector[VIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && is_event && !hnd_reg)
            cpu_mem[cpu_reg[CIW-1:0]] <= unh_new;
        if (cmd.capture)
            cpu_rd_reg <= cpu_mem[in_cpu[CIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg        <= in_cmd;
            cpu_reg        <= in_cpu;
            vec_reg        <= in_vector;
            hnd_reg        <= in_handled;
            ev_addr_reg    <= ev_addr_in[AW-1:0];
            vec_vld_rd_reg <= in_vec_ok && vec_vld_reg[in_vector[VIW-1:0]];
            cpu_vld_rd_reg <= in_cpu_ok && cpu_vld_reg[in_cpu[CIW-1:0]];
        end
        if (cmd.commit)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_vld_reg   <= '0;
            cpu_vld_reg   <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_en)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.commit && is_event)
            begin
                vec_vld_reg[vec_reg[VIW-1:0]] <= 1'b1;
                if (!hnd_reg)
                    cpu_vld_reg[cpu_reg[CIW-1:0]] <= 1'b1;
            end
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hw/rtl/interrupt_event_statistics_unit.sv */
// ============================================================================
// interrupt_event_statistics_unit
// Per-cpu, per-vector interrupt counters with one result per item.
//
// Items go one at a time: the accept cycle reads the counter memories
// (per cpu and vector, per vector, per cpu); then ST_UPDATE increments the
// 64-bit counters, writes them back and loads the result register. The rate
// is set by that single read-modify-write port on each memory; a result that
// is not taken holds the update until the result register frees. After reset
// the cpu-by-vector count memory is swept to zero, all NUM_CPUS * NUM_VECTORS
// entries (16384 by default), with s_tready low.
// ============================================================================
module interrupt_event_statistics_unit #(
    parameter int NUM_CPUS    = iesu_pkg::NUM_CPUS_DEF,
    parameter int NUM_VECTORS = iesu_pkg::NUM_VECTORS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [iesu_pkg::IN_W-1:0]   s_tdata,   // cpu, vector, handled
    input  logic [iesu_pkg::CMD_W-1:0]  s_tuser,   // cmd
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // vector_count, vector_total, cpu_unhandled, unhandled_streak,
    // vector_seen, cpu_valid
    output logic [iesu_pkg::OUT_W-1:0]  m_tdata
);
    import iesu_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    iesu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    iesu_dpath #(
        .NUM_CPUS    (NUM_CPUS),
        .NUM_VECTORS (NUM_VECTORS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_cmd     (s_tuser),
        .in_cpu     (s_tdata[IDX_W-1:0]),
        .in_vector  (s_tdata[2*IDX_W-1:IDX_W]),
        .in_handled (s_tdata[2*IDX_W]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

endmodule

/* hw/rtl/iesu_checker.sv */
// ============================================================================
// iesu_checker
// Port-level checks of the interrupt statistics unit, bound to the top.
// ============================================================================
`include "interrupt_event_statistics_unit_macros.svh"

module iesu_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [iesu_pkg::OUT_W-1:0]  m_tdata
);
    import iesu_pkg::*;

    // one item in flight: no accept right after an accept
    `IESU_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)

    `IESU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

    // cpu out of range: per-cpu fields read zero
    `IESU_ASSERT_NOW(a_cpu_invalid_zero, clk, rst_n, m_tvalid && !m_tdata[4*CNT_W+1],
        (m_tdata[CNT_W-1:0] == '0) && (m_tdata[3*CNT_W-1:2*CNT_W] == '0))

    // unseen vector has never been counted
    `IESU_ASSERT_NOW(a_unseen_zero, clk, rst_n, m_tvalid && !m_tdata[4*CNT_W],
        (m_tdata[2*CNT_W-1:0] == '0) && (m_tdata[4*CNT_W-1:3*CNT_W] == '0))

endmodule

bind interrupt_event_statistics_unit iesu_checker u_iesu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/interrupt_event_statistics_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interrupt_event_statistics_checker
// Watches both stream channels of the interrupt statistics unit, keeps its
// own copy of every counter, predicts the result of each accepted transfer
// and compares the returned results in order, field by field.
// ----------------------------------------------------------------------------
module interrupt_event_statistics_checker
    import iesu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // cpu, vector, handled
    input  logic [CMD_W-1:0]  s_tuser,   // cmd
    input  logic              m_tvalid,
    input  logic              m_tready,
    // vector_count, vector_total, cpu_unhandled, unhandled_streak,
    // vector_seen, cpu_valid
    input  logic [OUT_W-1:0]  m_tdata,
    output int                mismatches,
    output int                pending,
    output int                checked
);

    localparam int CPU_IW = (NUM_CPUS_DEF > 1) ? $clog2(NUM_CPUS_DEF) : 1;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] unhandled;
        logic [CNT_W-1:0] streak;
        logic             seen;
        logic             cpu_ok;
    } irq_stats_t;

    logic [CNT_W-1:0] cpu_vec_count [NUM_CPUS_DEF][NUM_VECTORS_DEF];
    logic [CNT_W-1:0] vec_total     [NUM_VECTORS_DEF];
    logic [CNT_W-1:0] cpu_unhandled [NUM_CPUS_DEF];
    logic [CNT_W-1:0] vec_streak    [NUM_VECTORS_DEF];
    logic             vec_seen      [NUM_VECTORS_DEF];

    irq_stats_t expected_stats [$];
    int         err_cnt;
    int         n_checked;

    function automatic irq_stats_t update_irq_counters(
        input logic [CMD_W-1:0] cmd,
        input logic [IDX_W-1:0] cpu,
        input logic [IDX_W-1:0] vec,
        input logic             handled
    );
        irq_stats_t        r;
        logic              cpu_ok;
        logic              vec_ok;
        logic [CPU_IW-1:0] ci;
        cpu_ok = cpu < NUM_CPUS_DEF;
        vec_ok = vec < NUM_VECTORS_DEF;
        ci     = cpu[CPU_IW-1:0];
        if (cmd == CMD_EVENT && cpu_ok && vec_ok)
        begin
            cpu_vec_count[ci][vec] += CNT_W'(1);
            vec_total[vec]         += CNT_W'(1);
            vec_seen[vec]           = 1'b1;
            if (handled)
            begin
                vec_streak[vec] = '0;
            end
            else
            begin
                cpu_unhandled[ci] += CNT_W'(1);
                vec_streak[vec]   += CNT_W'(1);
            end
        end
        else if (cmd == CMD_CLEAR && vec_ok)
        begin
            vec_streak[vec] = '0;
        end
        // unused code 3 behaves as a query
        r.count     = (cpu_ok && vec_ok) ? cpu_vec_count[ci][vec] : '0;
        r.total     = vec_ok ? vec_total[vec] : '0;
        r.unhandled = cpu_ok ? cpu_unhandled[ci] : '0;
        r.streak    = vec_ok ? vec_streak[vec] : '0;
        r.seen      = vec_ok && vec_seen[vec];
        r.cpu_ok    = cpu_ok;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("[%0t] MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                         $realtime, n_checked, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        irq_stats_t got;
        irq_stats_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CPUS_DEF; c++)
            begin
                cpu_unhandled[c] = '0;
                for (int v = 0; v < NUM_VECTORS_DEF; v++)
                    cpu_vec_count[c][v] = '0;
            end
            for (int v = 0; v < NUM_VECTORS_DEF; v++)
            begin
                vec_total[v]  = '0;
                vec_streak[v] = '0;
                vec_seen[v]   = 1'b0;
            end
            expected_stats.delete();
            err_cnt    = 0;
            n_checked  = 0;
            mismatches <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_stats.push_back(update_irq_counters(
                    s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[16]));
            if (m_tvalid && m_tready)
            begin
                got.count     = m_tdata[63:0];
                got.total     = m_tdata[127:64];
                got.unhandled = m_tdata[191:128];
                got.streak    = m_tdata[255:192];
                got.seen      = m_tdata[256];
                got.cpu_ok    = m_tdata[257];
                if (expected_stats.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("[%0t] MISMATCH unexpected result 0x%0h",
                                 $realtime, m_tdata);
                end
                else
                begin
                    want = expected_stats.pop_front();
                    check_field("vector_count", want.count, got.count);
                    check_field("vector_total", want.total, got.total);
                    check_field("cpu_unhandled", want.unhandled, got.unhandled);
                    check_field("unhandled_streak", want.streak, got.streak);
                    check_field("vector_seen", CNT_W'(want.seen), CNT_W'(got.seen));
                    check_field("cpu_valid", CNT_W'(want.cpu_ok), CNT_W'(got.cpu_ok));
                    n_checked++;
                end
            end
            mismatches <= err_cnt;
            pending    <= expected_stats.size();
            checked    <= n_checked;
        end
    end

endmodule

/* tb/interrupt_event_statistics_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interrupt_event_statistics_unit_tb
// Drives events, streak clears and queries into the interrupt statistics
// unit: a directed opening over the corner cases, then random traffic that
// mostly hammers a few hot cpu/vector pairs so counts and streaks grow, mixed
// with out-of-range cpus and fully random items. Both sides idle at random,
// and the receiver holds off once long enough to back up the input.
// ----------------------------------------------------------------------------
module interrupt_event_statistics_unit_tb;
    import iesu_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 400;
    localparam int HANG_LIMIT   = 60000;

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;   // cpu, vector, handled
    logic [CMD_W-1:0]  s_tuser  = '0;   // cmd
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // vector_count, vector_total, cpu_unhandled, unhandled_streak,
    // vector_seen, cpu_valid
    logic [OUT_W-1:0]  m_tdata;

    int  mismatches;
    int  pending;
    int  checked;
    int  n_items;
    int  n_events;
    int  n_clears;
    int  n_queries;
    int  n_bad_cpu;
    int  n_rx;
    int  idle_cycles = 0;
    bit  tx_steady;
    bit  rx_steady;

    logic [IDX_W-1:0] hot_cpu [4] = '{8'd0, 8'd5, 8'd17, 8'd63};
    logic [IDX_W-1:0] hot_vec [4] = '{8'd0, 8'd32, 8'd128, 8'd255};

    interrupt_event_statistics_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    interrupt_event_statistics_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // no transfer on either side for too long: hang
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", HANG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_irq_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] cpu,
                                 input logic [IDX_W-1:0] vec, input logic handled);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_W-17){1'b0}}, handled, vec, cpu};
        do @(posedge clk); while (!s_tready);
        n_items++;
        if (cpu >= NUM_CPUS_DEF)
            n_bad_cpu++;
        case (cmd)
            CMD_EVENT: n_events++;
            CMD_CLEAR: n_clears++;
            default:   n_queries++;
        endcase
    endtask

    // receiver: random stall after each result, one long hold-off
    initial
    begin
        int stall;
        n_rx = 0;
        rx_steady = 1'b0;
        @(posedge clk iff rst_n);
        m_tready <= 1'b1;
        forever
        begin
            do @(posedge clk); while (!(m_tvalid && m_tready));
            n_rx++;
            if (n_rx % 150 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            if (n_rx == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = rx_steady ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int r;
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] cpu;
        logic [IDX_W-1:0] vec;
        logic             handled;
        n_items = 0;
        n_events = 0;
        n_clears = 0;
        n_queries = 0;
        n_bad_cpu = 0;
        tx_steady = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        send_irq_item(CMD_QUERY,  8'd0,   8'd0,   1'b0);
        send_irq_item(CMD_EVENT,  8'd0,   8'd0,   1'b0);
        send_irq_item(CMD_EVENT,  8'd0,   8'd0,   1'b0);
        send_irq_item(CMD_EVENT,  8'd1,   8'd0,   1'b0);
        send_irq_item(CMD_EVENT,  8'd1,   8'd0,   1'b1);
        send_irq_item(CMD_EVENT,  8'd63,  8'd255, 1'b1);
        send_irq_item(CMD_EVENT,  8'd63,  8'd255, 1'b0);
        send_irq_item(CMD_EVENT,  8'd63,  8'd255, 1'b0);
        send_irq_item(CMD_EVENT,  8'd64,  8'd255, 1'b0);
        send_irq_item(CMD_EVENT,  8'd255, 8'd7,   1'b0);
        send_irq_item(CMD_QUERY,  8'd255, 8'd7,   1'b1);
        send_irq_item(CMD_UNUSED, 8'd63,  8'd255, 1'b1);
        send_irq_item(CMD_CLEAR,  8'd63,  8'd255, 1'b1);
        send_irq_item(CMD_QUERY,  8'd63,  8'd255, 1'b0);
        send_irq_item(CMD_CLEAR,  8'd200, 8'd7,   1'b0);
        send_irq_item(CMD_CLEAR,  8'd0,   8'd0,   1'b0);
        send_irq_item(CMD_EVENT,  8'd170, 8'd85,  1'b1);
        send_irq_item(CMD_EVENT,  8'd42,  8'd170, 1'b0);
        send_irq_item(CMD_UNUSED, 8'd128, 8'd128, 1'b0);
        send_irq_item(CMD_QUERY,  8'd1,   8'd0,   1'b1);

        // random
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
                tx_steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            handled = 1'($urandom_range(0, 1));
            cpu = hot_cpu[2'($urandom_range(0, 3))];
            vec = hot_vec[2'($urandom_range(0, 3))];
            if (r < 10)
            begin
                cmd = CMD_W'($urandom_range(0, 3));
                cpu = IDX_W'($urandom_range(0, 255));
                vec = IDX_W'($urandom_range(0, 255));
            end
            else if (r < 70)
            begin
                cmd = CMD_EVENT;
                handled = ($urandom_range(0, 3) == 0);
            end
            else if (r < 80)
            begin
                cmd = CMD_EVENT;
                cpu = IDX_W'($urandom_range(0, NUM_CPUS_DEF - 1));
                vec = IDX_W'($urandom_range(0, 255));
            end
            else if (r < 88)
                cmd = CMD_CLEAR;
            else
                cmd = ($urandom_range(0, 1) == 0) ? CMD_QUERY : CMD_UNUSED;
            send_irq_item(cmd, cpu, vec, handled);
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d items: %0d events, %0d clears, %0d queries, %0d with cpu out of range",
                 n_items, n_events, n_clears, n_queries, n_bad_cpu);
        $display("Checked %0d results, one receiver hold-off of %0d cycles, %0d mismatches",
                 checked, HOLD_CYCLES, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/iesu_pkg.sv
hw/rtl/iesu_ctrl.sv
hw/rtl/iesu_dpath.sv
hw/rtl/interrupt_event_statistics_unit.sv
hw/rtl/iesu_checker.sv
tb/interrupt_event_statistics_checker.sv
tb/interrupt_event_statistics_unit_tb.sv
